// ----- hw/rtl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for the extended Hamming SECDED codec: field
// widths, command and status codes, data bit placement and check coverage.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int MAX_CHECK_BITS = 5;
  localparam int MAX_DATA_BITS  = 26;
  localparam int MIN_CHECK_BITS = 3;
  localparam int CODE_W         = 32;
  localparam int SYN_W          = 5;
  localparam int CFG_W          = 5;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam logic [CFG_W-1:0] DATA_BITS_RESET = CFG_W'(26);

  typedef enum logic [0:0] {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_PARITY = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_DATA_BITS = 1'b0,
    REG_UNUSED    = 1'b1
  } reg_index_t;

  typedef logic [SYN_W-1:0] pos_t;

  localparam pos_t DATA_POS [MAX_DATA_BITS] = '{
    5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
    5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
  };

  localparam logic [CODE_W-1:0] COVER [MAX_CHECK_BITS] = '{
    32'hAAAA_AAAA,
    32'hCCCC_CCCC,
    32'hF0F0_F0F0,
    32'hFF00_FF00,
    32'hFFFF_0000
  };

  typedef struct packed {
    logic [CODE_W-1:0]        code_word;
    logic [MAX_DATA_BITS-1:0] data_out;
    status_t                  status;
    logic [SYN_W-1:0]         syndrome;
  } result_t;

endpackage

// ----- hw/rtl/hsc_codec.sv -----
// ----------------------------------------------------------------------------
// hsc_codec
// Single-pass encode/decode datapath: derives the check bit count and word
// length from the data length, then builds or repairs one codeword.
// ----------------------------------------------------------------------------
module hsc_codec (
  input  logic [hsc_pkg::CFG_W-1:0]         data_bits,
  input  hsc_pkg::cmd_t                     command,
  input  logic [hsc_pkg::MAX_DATA_BITS-1:0] data_word,
  input  logic [hsc_pkg::CODE_W-1:0]        received_word,
  output hsc_pkg::result_t                  result
);
  import hsc_pkg::*;

  logic [CFG_W-1:0]         k;
  logic [2:0]               m;
  logic [CFG_W:0]           n;
  logic [CODE_W-1:0]        pos_mask;
  logic [MAX_DATA_BITS-1:0] data_mask;
  logic [MAX_CHECK_BITS-1:0] chk_mask;
  logic [CODE_W-1:0]        enc_data;
  logic [CODE_W-1:0]        enc_word;
  logic [CODE_W-1:0]        dec_word;
  logic [CODE_W-1:0]        fix_word;
  logic [SYN_W-1:0]         syn;
  logic                     par;
  status_t                  dec_status;
  logic [MAX_DATA_BITS-1:0] dec_data;

  always_comb begin
    if (data_bits == '0) begin
      k = CFG_W'(1);
    end else if (data_bits > CFG_W'(MAX_DATA_BITS)) begin
      k = CFG_W'(MAX_DATA_BITS);
    end else begin
      k = data_bits;
    end
    m = 3'(MAX_CHECK_BITS);
    for (int j = MAX_CHECK_BITS - 1; j >= MIN_CHECK_BITS; j--) begin
      if ((7'(k) + 7'(j)) < 7'(1 << j)) begin
        m = 3'(j);
      end
    end
    n = (CFG_W+1)'(k) + (CFG_W+1)'(m);
    for (int p = 0; p < CODE_W; p++) begin
      pos_mask[p] = ((CFG_W+1)'(p) <= n);
    end
    for (int b = 0; b < MAX_DATA_BITS; b++) begin
      data_mask[b] = (CFG_W'(b) < k);
    end
    for (int i = 0; i < MAX_CHECK_BITS; i++) begin
      chk_mask[i] = (3'(i) < m);
    end
  end

  always_comb begin
    enc_data = '0;
    for (int b = 0; b < MAX_DATA_BITS; b++) begin
      enc_data[DATA_POS[b]] = data_word[b] & data_mask[b];
    end
    enc_word = enc_data;
    for (int i = 0; i < MAX_CHECK_BITS; i++) begin
      enc_word[2**i] = (^(enc_data & COVER[i])) & chk_mask[i];
    end
    enc_word[0] = ^enc_word[CODE_W-1:1];
  end

  always_comb begin
    dec_word = received_word & pos_mask;
    par      = ^dec_word;
    for (int i = 0; i < SYN_W; i++) begin
      syn[i] = (^(dec_word & COVER[i])) & chk_mask[i];
    end
    fix_word   = dec_word;
    dec_status = ST_NONE;
    if (syn == '0) begin
      if (par) begin
        dec_status  = ST_PARITY;
        fix_word[0] = ~dec_word[0];
      end
    end else if (par) begin
      dec_status = ST_SINGLE;
      if ((CFG_W+1)'(syn) <= n) begin
        fix_word = dec_word ^ (CODE_W'(1) << syn);
      end
    end else begin
      dec_status = ST_DOUBLE;
    end
    for (int b = 0; b < MAX_DATA_BITS; b++) begin
      dec_data[b] = fix_word[DATA_POS[b]];
    end
  end

  always_comb begin
    if (command == CMD_DECODE) begin
      result.code_word = fix_word;
      result.data_out  = dec_data;
      result.status    = dec_status;
      result.syndrome  = syn;
    end else begin
      result.code_word = enc_word;
      result.data_out  = data_word & data_mask;
      result.status    = ST_NONE;
      result.syndrome  = '0;
    end
  end

endmodule

// ----- hw/rtl/hamming_secded_codec.sv -----
// ----------------------------------------------------------------------------
// hamming_secded_codec
// Extended Hamming SECDED encoder/decoder with a programmable data length.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carries command, data_word and
// received_word. Output channel: out_valid/out_ready carries code_word,
// data_out, status and syndrome. Each input transfer yields exactly one
// output transfer, in order.
// From input transfer to out_valid, an item passes one input register, then
// the XOR trees and repair mux into the result register.
// Throughput is one item per cycle while out_ready stays high; the input
// register and the result register each hold one item, so a new item enters
// while a finished result waits for the receiver.
// When out_ready is low, the result register holds and the input register
// fills; in_ready drops only when both are occupied.
// The APB register data_bits (address 0) sets the data length; write it only
// while no item is in flight. Reset empties both stages and sets data_bits
// to 26.
// ----------------------------------------------------------------------------
module hamming_secded_codec (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hsc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hsc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hsc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [hsc_pkg::MAX_DATA_BITS-1:0] data_word,
  input  logic [hsc_pkg::CODE_W-1:0]        received_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hsc_pkg::CODE_W-1:0]        code_word,
  output logic [hsc_pkg::MAX_DATA_BITS-1:0] data_out,
  output logic [1:0]                        status,
  output logic [hsc_pkg::SYN_W-1:0]         syndrome
);
  import hsc_pkg::*;

  logic [CFG_W-1:0]         data_bits;
  logic                     s1_valid;
  cmd_t                     s1_command;
  logic [MAX_DATA_BITS-1:0] s1_data_word;
  logic [CODE_W-1:0]        s1_received_word;
  result_t                  result_next;
  result_t                  result;
  logic                     advance;
  logic                     reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (reg_index_t'(paddr[APB_ADDR_W-1]) == REG_DATA_BITS);
  assign prdata  = reg_hit ? APB_DATA_W'(data_bits) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_bits <= DATA_BITS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      data_bits <= pwdata[CFG_W-1:0];
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command       <= cmd_t'(command);
      s1_data_word     <= data_word;
      s1_received_word <= received_word;
    end
  end

  hsc_codec u_codec (
    .data_bits     (data_bits),
    .command       (s1_command),
    .data_word     (s1_data_word),
    .received_word (s1_received_word),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign code_word = result.code_word;
  assign data_out  = result.data_out;
  assign status    = result.status;
  assign syndrome  = result.syndrome;

`ifndef SYNTH
  a_in_to_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transfer did not reach the input stage");

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the result register");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !s1_valid |=> !out_valid)
    else $error("result repeated after its transfer");

  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    advance && (s1_command == CMD_ENCODE) |=>
      (status == ST_NONE) && (syndrome == '0))
    else $error("encode result carries error status or syndrome");
`endif

endmodule

// ----- bench/hamming_secded_codec_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_secded_codec_test
// Self-checking bench for the SECDED codec. Encode and decode items are sent
// at several data lengths, including out-of-range settings. Each result is
// checked against an in-bench predictor under random sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module hamming_secded_codec_test;
  import hsc_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr         = '0;
  logic [APB_DATA_W-1:0]     pwdata        = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic                      command       = 1'b0;
  logic [MAX_DATA_BITS-1:0]  data_word     = '0;
  logic [CODE_W-1:0]         received_word = '0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic [CODE_W-1:0]         code_word;
  logic [MAX_DATA_BITS-1:0]  data_out;
  logic [1:0]                status;
  logic [SYN_W-1:0]          syndrome;

  logic [CFG_W-1:0] cfg_data_bits = DATA_BITS_RESET;
  result_t          pending_results [$];
  int               mismatch_count  = 0;
  int               send_idle_pct   = 0;
  int               recv_stall_pct  = 0;
  int               hold_requests   = 0;
  int               hold_seen       = 0;
  int               hold_left       = 0;
  int               quiet_cycles    = 0;

  hamming_secded_codec DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_word    (data_word),
    .received_word(received_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_word    (code_word),
    .data_out     (data_out),
    .status       (status),
    .syndrome     (syndrome)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(string what);
    if (mismatch_count < 40) begin
      $display("ERROR: %s", what);
    end
    mismatch_count++;
  endtask

  function automatic void code_geometry(output int k, output int m, output int n);
    k = cfg_data_bits;
    if (k < 1) k = 1;
    if (k > MAX_DATA_BITS) k = MAX_DATA_BITS;
    m = MIN_CHECK_BITS;
    while (m < MAX_CHECK_BITS && (1 << m) <= k + m) m++;
    n = k + m;
  endfunction

  function automatic logic cover_parity(logic [CODE_W-1:0] w, int i, int n);
    logic s;
    s = 1'b0;
    for (int p = 1; p <= n; p++) begin
      if (((p >> i) & 1) != 0) s ^= w[p];
    end
    return s;
  endfunction

  function automatic result_t compute_codec_result(cmd_t cmd, logic [MAX_DATA_BITS-1:0] dw,
                                                   logic [CODE_W-1:0] rw);
    int      k, m, n, b;
    logic    par;
    result_t r;
    code_geometry(k, m, n);
    r = '0;
    b = 0;
    if (cmd == CMD_ENCODE) begin
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          r.code_word[p] = dw[b];
          b++;
        end
      end
      for (int i = 0; i < m; i++) r.code_word[1 << i] = cover_parity(r.code_word, i, n);
      r.code_word[0] = ^r.code_word;
      r.data_out = dw & ~({MAX_DATA_BITS{1'b1}} << k);
    end else begin
      r.code_word = rw & ~(32'hFFFF_FFFF << (n + 1));
      par = ^r.code_word;
      for (int i = 0; i < m; i++) r.syndrome[i] = cover_parity(r.code_word, i, n);
      if (r.syndrome == '0) begin
        if (par) begin
          r.status = ST_PARITY;
          r.code_word[0] = ~r.code_word[0];
        end
      end else if (par) begin
        r.status = ST_SINGLE;
        if (r.syndrome <= n) r.code_word[r.syndrome] = ~r.code_word[r.syndrome];
      end else begin
        r.status = ST_DOUBLE;
      end
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          r.data_out[b] = r.code_word[p];
          b++;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(cmd_t cmd, logic [MAX_DATA_BITS-1:0] dw, logic [CODE_W-1:0] rw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    data_word     <= dw;
    received_word <= rw;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(compute_codec_result(cmd, dw, rw));
  endtask

  task automatic send_random_item;
    cmd_t                     cmd;
    logic [MAX_DATA_BITS-1:0] dw;
    logic [CODE_W-1:0]        rw;
    result_t                  golden;
    int                       k, m, n, kind, p1, p2;
    cmd = cmd_t'($urandom_range(1));
    dw  = MAX_DATA_BITS'($urandom);
    rw  = $urandom;
    if (cmd == CMD_DECODE) begin
      code_geometry(k, m, n);
      kind = $urandom_range(9);
      if (kind < 9) begin
        golden = compute_codec_result(CMD_ENCODE, MAX_DATA_BITS'($urandom), '0);
        rw = golden.code_word;
        p1 = $urandom_range(n);
        p2 = (p1 + 1 + $urandom_range(n - 1)) % (n + 1);
        if (kind >= 2) rw[p1] = ~rw[p1];
        if (kind >= 5) rw[p2] = ~rw[p2];
        if (kind == 7) rw ^= 32'h1 << $urandom_range(n);
        if (kind == 8) rw |= $urandom & (32'hFFFF_FFFF << (n + 1));
      end
    end
    send_item(cmd, dw, rw);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_read(output logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * REG_DATA_BITS);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    value = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_data_bits(logic [CFG_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_DATA_BITS);
    pwdata  <= {(APB_DATA_W - CFG_W)'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_data_bits = v;
    apb_read(rd);
    if (rd[CFG_W-1:0] !== v) begin
      report_error($sformatf("data_bits readback %h expected %h", rd[CFG_W-1:0], v));
    end
  endtask

  task automatic test_reset_value;
    logic [APB_DATA_W-1:0] rd;
    apb_read(rd);
    if (rd[CFG_W-1:0] !== DATA_BITS_RESET) begin
      report_error($sformatf("data_bits after reset %h", rd[CFG_W-1:0]));
    end
  endtask

  task automatic test_directed_items;
    logic [CODE_W-1:0] cw;
    result_t           golden;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(CMD_ENCODE, '0, '0);
    send_item(CMD_ENCODE, '1, '1);
    send_item(CMD_ENCODE, 26'h2AA_AAAA, 32'h5555_5555);
    golden = compute_codec_result(CMD_ENCODE, 26'h155_5555, '0);
    cw = golden.code_word;
    send_item(CMD_DECODE, '0, cw);
    send_item(CMD_DECODE, '0, cw ^ 32'h0000_0001);
    send_item(CMD_DECODE, '0, cw ^ 32'h0000_0002);
    send_item(CMD_DECODE, '0, cw ^ 32'h8000_0000);
    send_item(CMD_DECODE, '0, cw ^ 32'h0001_0000);
    send_item(CMD_DECODE, '1, cw ^ 32'h0000_0018);
    send_item(CMD_DECODE, '0, '1);
    send_item(CMD_DECODE, '0, '0);
    // shortest word: syndrome past the end of the word, junk above it
    set_data_bits(CFG_W'(1));
    send_item(CMD_ENCODE, '1, '0);
    send_item(CMD_DECODE, '0, 32'hFFFF_FFE0 | 32'h16);
    send_item(CMD_DECODE, '0, 32'h0000_0001);
    set_data_bits(CFG_W'(0));
    send_item(CMD_ENCODE, '1, '0);
    send_item(CMD_DECODE, '0, 32'h0000_001F);
    set_data_bits(CFG_W'(31));
    golden = compute_codec_result(CMD_ENCODE, '1, '0);
    cw = golden.code_word;
    send_item(CMD_ENCODE, '1, '0);
    send_item(CMD_DECODE, '0, cw ^ 32'h0000_0004);
    send_item(CMD_DECODE, '0, '1);
    set_data_bits(CFG_W'(11));
    send_item(CMD_ENCODE, '1, '0);
    set_data_bits(CFG_W'(12));
    send_item(CMD_ENCODE, '1, '0);
  endtask

  task automatic test_random_traffic;
    int k_table [16] = '{26, 1, 11, 12, 0, 31, 4, 5, 25, 2, 17, 26, 7, 20, 1, 3};
    for (int phase = 0; phase < 16; phase++) begin
      set_data_bits(phase == 15 ? CFG_W'($urandom_range(31)) : CFG_W'(k_table[phase]));
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 50;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase
      repeat (100) send_random_item();
    end
  endtask

  task automatic test_backpressure;
    set_data_bits(CFG_W'(26));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (30) send_random_item();
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error("result transfer with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (code_word !== want.code_word)
          report_error($sformatf("code_word %h expected %h", code_word, want.code_word));
        if (data_out !== want.data_out)
          report_error($sformatf("data_out %h expected %h", data_out, want.data_out));
        if (status !== want.status)
          report_error($sformatf("status %0d expected %0d", status, want.status));
        if (syndrome !== want.syndrome)
          report_error($sformatf("syndrome %0d expected %0d", syndrome, want.syndrome));
      end
    end
  end

  always @(posedge clk) begin : receiver_hold
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_value();
    test_directed_items();
    test_random_traffic();
    test_backpressure();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
